[hdl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge except while reset is high
`define ISRS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("isrs check failed");

// checked at every edge, reset included
`define ISRS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("isrs check failed");

`endif

[hdl/isrs_pkg.sv]
package isrs_pkg;

   localparam int NUM_CNT     = 11;
   localparam int FIELD_W     = 16;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 192;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam int CNT_TOTAL   = 0;
   localparam int CNT_VALID   = 1;
   localparam int CNT_LOST    = 2;
   localparam int CNT_ERROR   = 3;
   localparam int CNT_BADLEN  = 4;
   localparam int CNT_GAPPKT  = 5;
   localparam int CNT_GAPEVT  = 6;
   localparam int CNT_OLDDUP  = 7;
   localparam int CNT_TXOK    = 8;
   localparam int CNT_TXALLOC = 9;
   localparam int CNT_TXSEND  = 10;

   localparam logic [15:0] SEQ_HALF       = 16'h8000;
   localparam logic [15:0] U16_MAX        = 16'hFFFF;
   localparam logic [15:0] MAX_LEN_RESET  = 16'd251;

   typedef enum logic [2:0] {
      MODE_RX_PACKET     = 3'd0,
      MODE_TX_OK         = 3'd1,
      MODE_TX_ALLOC_FAIL = 3'd2,
      MODE_TX_SEND_FAIL  = 3'd3,
      MODE_REPORT        = 3'd4,
      MODE_SEQ_RESET     = 3'd5
   } mode_type;

   typedef struct packed {
      logic [NUM_CNT-1:0] bump;
      logic [15:0]        gap_delta;
      logic               report;
      logic [31:0]        now_ms;
   } cmd_type;

endpackage

[hdl/isrs_front.sv]
module isrs_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [isrs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [2:0]                      req_tuser,
   input  logic                            csr_wr_en,
   input  logic [15:0]                     csr_wr_data,
   input  logic                            queue_full,
   output logic                            push_valid,
   output isrs_pkg::cmd_type               push_cmd
);
   import isrs_pkg::*;

   logic [15:0] max_len_ff, max_len_in;
   logic [15:0] exp_seq_ff, exp_seq_in;
   logic        seq_known_ff, seq_known_in;

   logic        accept;
   logic        need_push;
   logic [15:0] seq;
   logic [15:0] len;
   logic [15:0] delta;
   logic        fv, fl, fe, bp;

   assign seq   = req_tdata[15:0];
   assign fv    = req_tdata[16];
   assign fl    = req_tdata[17];
   assign fe    = req_tdata[18];
   assign bp    = req_tdata[19];
   assign len   = req_tdata[35:20];
   assign delta = seq - exp_seq_ff;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && !queue_full;
   assign push_valid = accept && need_push;

   always_comb begin
      push_cmd        = '0;
      push_cmd.now_ms = req_tdata[67:36];
      need_push       = 1'b0;
      exp_seq_in      = exp_seq_ff;
      seq_known_in    = seq_known_ff;
      case (req_tuser)
         MODE_RX_PACKET: begin
            need_push = 1'b1;
            push_cmd.bump[CNT_TOTAL] = 1'b1;
            push_cmd.bump[CNT_VALID] = fv;
            push_cmd.bump[CNT_LOST]  = fl;
            push_cmd.bump[CNT_ERROR] = fe;
            push_cmd.bump[CNT_BADLEN] = !bp || (len == 16'd0) || (len > max_len_ff);
            if (seq_known_ff) begin
               if (delta != 16'd0 && delta < SEQ_HALF) begin
                  push_cmd.bump[CNT_GAPEVT] = 1'b1;
                  push_cmd.bump[CNT_GAPPKT] = 1'b1;
                  push_cmd.gap_delta        = delta;
               end else if (delta >= SEQ_HALF) begin
                  push_cmd.bump[CNT_OLDDUP] = 1'b1;
               end
            end
            exp_seq_in   = seq + 16'd1;
            seq_known_in = 1'b1;
         end
         MODE_TX_OK: begin
            need_push = 1'b1;
            push_cmd.bump[CNT_TXOK] = 1'b1;
         end
         MODE_TX_ALLOC_FAIL: begin
            need_push = 1'b1;
            push_cmd.bump[CNT_TXALLOC] = 1'b1;
         end
         MODE_TX_SEND_FAIL: begin
            need_push = 1'b1;
            push_cmd.bump[CNT_TXSEND] = 1'b1;
         end
         MODE_REPORT: begin
            need_push       = 1'b1;
            push_cmd.report = 1'b1;
         end
         MODE_SEQ_RESET: begin
            seq_known_in = 1'b0;
         end
         default: begin
            need_push = 1'b0;
         end
      endcase
   end

   assign max_len_in = csr_wr_en ? csr_wr_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LEN_RESET;
         exp_seq_ff   <= '0;
         seq_known_ff <= 1'b0;
      end else begin
         max_len_ff <= max_len_in;
         if (accept) begin
            exp_seq_ff   <= exp_seq_in;
            seq_known_ff <= seq_known_in;
         end
      end
   end

endmodule

[hdl/isrs_queue.sv]
module isrs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  isrs_pkg::cmd_type push_cmd,
   output logic              full,
   output logic              pop_valid,
   input  logic              pop_ready,
   output isrs_pkg::cmd_type pop_cmd
);
   import isrs_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hdl/isrs_back.sv]
module isrs_back #(
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  isrs_pkg::cmd_type               pop_cmd,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [isrs_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import isrs_pkg::*;

   logic [COUNTER_WIDTH-1:0] cnt_ff [NUM_CNT];
   logic [COUNTER_WIDTH-1:0] cnt_in [NUM_CNT];
   logic [31:0]              last_time_ff, last_time_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                     take;
   logic                     take_report;
   logic [31:0]              elapsed;
   logic [15:0]              interval;
   logic [COUNTER_WIDTH-1:0] gap_amount;

   assign pop_ready   = !pop_cmd.report || !rsp_valid_ff || rsp_tready;
   assign take        = pop_valid && pop_ready;
   assign take_report = take && pop_cmd.report;
   assign gap_amount  = COUNTER_WIDTH'(pop_cmd.gap_delta);
   assign elapsed     = pop_cmd.now_ms - last_time_ff;
   assign interval    = (elapsed[31:16] != 16'd0) ? U16_MAX : elapsed[15:0];

   always_comb begin
      for (int i = 0; i < NUM_CNT; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (take && pop_cmd.bump[i]) begin
            cnt_in[i] = cnt_ff[i] + ((i == CNT_GAPPKT) ? gap_amount : COUNTER_WIDTH'(1));
         end
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (take_report) begin
         rsp_data_in[FIELD_W-1:0] = interval;
         for (int i = 0; i < NUM_CNT; i++) begin
            rsp_data_in[FIELD_W*(i+1) +: FIELD_W] = cnt_ff[i][FIELD_W-1:0];
         end
      end
   end

   assign last_time_in = take_report ? pop_cmd.now_ms : last_time_ff;
   assign rsp_valid_in = take_report ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CNT; i++) begin
            cnt_ff[i] <= '0;
         end
         last_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_CNT; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
         last_time_ff <= last_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hdl/iso_rx_sequence_stats.sv]
// a report passes through the queue entry and then the output register before it shows on rsp
// throughput: one item per cycle while the queue is not full; a report waits only while the output register is held
// the front tracks the sequence number, the back updates the counters after a 4-entry queue
// reset (synchronous, active high) clears counters, sequence state and report time,
// empties the queue and output register, and sets max_packet_length to 251
module iso_rx_sequence_stats #(
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // seq_number, flag_valid, flag_lost, flag_error, buffer_present,
   // payload_length, now_ms, zero fill
   input  logic [isrs_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic [2:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // report_gap_ms, rx_total, rx_valid, rx_lost, rx_errors, rx_bad_length,
   // gap_packets, gap_events, old_or_duplicate, tx_ok_count,
   // tx_alloc_fail_count, tx_send_fail_count
   output logic [isrs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [15:0]                     csr_wr_data
);
   import isrs_pkg::*;

   logic    queue_full;
   logic    push_valid;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   isrs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   isrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   isrs_back #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[hdl/isrs_checker.sv]
`include "assert_macros.svh"

module isrs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [2:0]                      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [isrs_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import isrs_pkg::*;

   // output register is empty right after reset
   `ISRS_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_tvalid)

   // queue is empty right after reset, so the input side is open
   `ISRS_ASSERT_ALWAYS(a_req_open_after_reset, clock, reset |=> req_tready)

   // a held result keeps its data
   `ISRS_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // a report taken while all is quiet shows after the queue entry and output register
   `ISRS_ASSERT(a_report_latency, clock, reset,
      req_tvalid && req_tready && (req_tuser == MODE_REPORT) && !rsp_tvalid
      && $past(!rsp_tvalid && !(req_tvalid && req_tready), 1)
      && $past(!rsp_tvalid && !(req_tvalid && req_tready), 2)
      && $past(!rsp_tvalid && !(req_tvalid && req_tready), 3)
      && $past(!rsp_tvalid && !(req_tvalid && req_tready), 4) |-> ##2 rsp_tvalid)

endmodule

bind iso_rx_sequence_stats isrs_checker u_isrs_checker (.*);
